// File: rtl/core/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg
// Shared codes and types for the pixel replicating upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

	// request kinds carried on the input tuser
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	// byte phase within one pixel copy: blue, green, red, then line padding
	typedef enum logic [1:0] {
		PH_BLUE  = 2'd0,
		PH_GREEN = 2'd1,
		PH_RED   = 2'd2,
		PH_PAD   = 2'd3
	} phase_t;

	// register byte addresses on the configuration port
	localparam logic [2:0] REG_SCALE    = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH = 3'd4;

	// register field widths and scale limit
	localparam int SCALE_W = 5;
	localparam int WIDTH_W = 13;
	localparam logic [SCALE_W-1:0] SCALE_MAX = 5'd16;

	// result flags carried from the control stage to the output register
	typedef struct packed {
		logic   out_valid;
		logic   line_end;
		logic   group_end;
		logic   pixel_taken;
		logic   pad_byte;
		phase_t phase;
	} res_ctl_t;

endpackage

// File: rtl/core/pixel_replicate_upscaler.sv
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbor upscaler: holds one row of 24-bit pixels in a line
// memory and replays it as padded byte lines, scale copies of scale repeats.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is registered in stage 1 (control flags and
// memory read data), then in the output register, which holds while stalled.
// Throughput: one request per cycle unless m_tready back-pressure stalls it;
// the line memory has one write port for pushes, one registered read for pulls.
// Reset: counters and valid flags clear at once, scale and in_width go to 1;
// line memory contents stay undefined until written, with no clearing pass.
module pixel_replicate_upscaler #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
	input  logic        s_tuser,   // [0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [2:0]  m_tuser,   // [0] out_valid, [1] group_end, [2] pixel_taken
	output logic        m_tlast,   // line_end
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int FW = $clog2(MAX_WIDTH + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = (FW > pru_pkg::WIDTH_W) ? FW : pru_pkg::WIDTH_W;

	// configuration registers
	logic [pru_pkg::SCALE_W-1:0] scale_q;
	logic [pru_pkg::WIDTH_W-1:0] in_width_q;

	// row state
	logic [FW-1:0]     fill_q;
	logic              row_full_q;
	logic [3:0]        copy_q;
	logic [AW-1:0]     src_q;
	logic [3:0]        rep_q;
	pru_pkg::phase_t   phase_q;
	logic [1:0]        pad_cnt_q;

	// next-state values
	logic [FW-1:0]     fill_d;
	logic              row_full_d;
	logic [3:0]        copy_d;
	logic [AW-1:0]     src_d;
	logic [3:0]        rep_d;
	pru_pkg::phase_t   phase_d;
	logic [1:0]        pad_cnt_d;

	// effective limits
	logic [pru_pkg::SCALE_W-1:0] s_eff;
	logic [CW-1:0]     w_eff;
	logic [1:0]        prod2;
	logic [1:0]        tri2;
	logic [1:0]        pad_len;

	// handshakes and pipeline
	logic              acc;
	logic              adv1;
	logic              valid_s1;
	pru_pkg::res_ctl_t ctl_d;
	pru_pkg::res_ctl_t ctl_s1;
	pru_pkg::res_ctl_t ctl_q;
	logic [7:0]        byte_s1;
	logic [7:0]        byte_q;
	logic              out_full_q;

	// line memory
	logic [23:0]       line_mem [MAX_WIDTH];
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [23:0]       rdata_s1;

	logic [FW-1:0]     fill_inc;
	logic [4:0]        rep_inc;
	logic [4:0]        copy_inc;
	logic [2:0]        pad_inc;
	logic [CW-1:0]     src_inc;

	// configuration port, writes on the access cycle
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= pru_pkg::SCALE_W'(1);
			in_width_q <= pru_pkg::WIDTH_W'(1);
		end else if (psel && penable && pwrite) begin
			if (paddr == pru_pkg::REG_SCALE)
				scale_q <= pwdata[pru_pkg::SCALE_W-1:0];
			else if (paddr == pru_pkg::REG_IN_WIDTH)
				in_width_q <= pwdata[pru_pkg::WIDTH_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == pru_pkg::REG_SCALE)
			prdata = 32'(scale_q);
		else if (paddr == pru_pkg::REG_IN_WIDTH)
			prdata = 32'(in_width_q);
	end

	// clamp scale and width, padding length from the low bits of 3*w*s
	always_comb begin
		if (scale_q == '0)
			s_eff = pru_pkg::SCALE_W'(1);
		else if (scale_q > pru_pkg::SCALE_MAX)
			s_eff = pru_pkg::SCALE_MAX;
		else
			s_eff = scale_q;

		if (in_width_q == '0)
			w_eff = CW'(1);
		else if (CW'(in_width_q) > CW'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(in_width_q);

		prod2   = 2'(w_eff[1:0] * s_eff[1:0]);
		tri2    = 2'(prod2 * 2'd3);
		pad_len = 2'(2'd0 - tri2);
	end

	// pipeline moves when the output register is free or being taken
	assign adv1     = !out_full_q || m_tready;
	assign s_tready = !valid_s1 || adv1;
	assign acc      = s_tvalid && s_tready;

	assign fill_inc = fill_q + FW'(1);
	assign rep_inc  = 5'(rep_q) + 5'd1;
	assign copy_inc = 5'(copy_q) + 5'd1;
	assign pad_inc  = 3'(pad_cnt_q) + 3'd1;
	assign src_inc  = CW'(src_q) + CW'(1);

	// row control: push fills the store, pull walks pixel, repeat, padding, copy
	always_comb begin
		logic finish;
		finish     = 1'b0;
		fill_d     = fill_q;
		row_full_d = row_full_q;
		copy_d     = copy_q;
		src_d      = src_q;
		rep_d      = rep_q;
		phase_d    = phase_q;
		pad_cnt_d  = pad_cnt_q;
		ctl_d      = '0;
		ctl_d.phase = phase_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = fill_q[AW-1:0];
		mem_raddr  = src_q;

		if (acc && s_tuser == pru_pkg::FUNC_PUSH) begin
			if (!row_full_q && CW'(fill_q) < CW'(MAX_WIDTH)) begin
				mem_we            = 1'b1;
				fill_d            = fill_inc;
				ctl_d.pixel_taken = 1'b1;
				if (CW'(fill_inc) >= w_eff)
					row_full_d = 1'b1;
			end
		end else if (acc && row_full_q) begin
			ctl_d.out_valid = 1'b1;
			if (phase_q == pru_pkg::PH_PAD) begin
				ctl_d.pad_byte = 1'b1;
				pad_cnt_d      = pad_inc[1:0];
				if (pad_inc >= 3'(pad_len))
					finish = 1'b1;
			end else begin
				mem_re = 1'b1;
				if (phase_q == pru_pkg::PH_RED) begin
					phase_d = pru_pkg::PH_BLUE;
					rep_d   = rep_inc[3:0];
					if (rep_inc >= s_eff) begin
						rep_d = '0;
						if (src_inc >= w_eff) begin
							if (pad_len != 2'd0) begin
								phase_d   = pru_pkg::PH_PAD;
								pad_cnt_d = '0;
							end else begin
								finish = 1'b1;
							end
						end else begin
							src_d = src_inc[AW-1:0];
						end
					end
				end else begin
					phase_d = pru_pkg::phase_t'(2'(phase_q) + 2'd1);
				end
			end

			// end of one output line, and of the row after the last copy
			if (finish) begin
				src_d          = '0;
				rep_d          = '0;
				phase_d        = pru_pkg::PH_BLUE;
				pad_cnt_d      = '0;
				ctl_d.line_end = 1'b1;
				if (copy_inc >= s_eff) begin
					copy_d          = '0;
					row_full_d      = 1'b0;
					fill_d          = '0;
					ctl_d.group_end = 1'b1;
				end else begin
					copy_d = copy_inc[3:0];
				end
			end
		end
	end

	// row state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			row_full_q <= 1'b0;
			copy_q     <= '0;
			src_q      <= '0;
			rep_q      <= '0;
			phase_q    <= pru_pkg::PH_BLUE;
			pad_cnt_q  <= '0;
		end else begin
			fill_q     <= fill_d;
			row_full_q <= row_full_d;
			copy_q     <= copy_d;
			src_q      <= src_d;
			rep_q      <= rep_d;
			phase_q    <= phase_d;
			pad_cnt_q  <= pad_cnt_d;
		end
	end

	// line memory: a push writes before any later pull can read the entry,
	// and read data holds while the stage is stalled since reads follow accepts
	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_waddr] <= s_tdata;
		if (mem_re)
			rdata_s1 <= line_mem[mem_raddr];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc)
			ctl_s1 <= ctl_d;
	end

	// byte select from the stored pixel, zero for padding and empty results
	always_comb begin
		byte_s1 = 8'h00;
		if (ctl_s1.out_valid && !ctl_s1.pad_byte) begin
			unique case (ctl_s1.phase)
				pru_pkg::PH_BLUE:  byte_s1 = rdata_s1[7:0];
				pru_pkg::PH_GREEN: byte_s1 = rdata_s1[15:8];
				pru_pkg::PH_RED:   byte_s1 = rdata_s1[23:16];
				default:           byte_s1 = 8'h00;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_full_q <= 1'b0;
		else if (adv1)
			out_full_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) begin
			ctl_q  <= ctl_s1;
			byte_q <= byte_s1;
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = {ctl_q.pixel_taken, ctl_q.group_end, ctl_q.out_valid};
	assign m_tlast  = ctl_q.line_end;

	// the last byte of a row always closes a line
	a_group_is_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("group_end without line_end");

	// a result is either a stored push or a pulled byte, never both
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
		else $error("pixel_taken and out_valid together");

	// readout counters rest at zero while no row is held
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!row_full_q |-> (phase_q == pru_pkg::PH_BLUE && src_q == '0 &&
			rep_q == '0 && copy_q == '0 && pad_cnt_q == '0))
		else $error("readout counters moved without a full row");

	// padding never needs a fourth byte
	a_pad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pad_cnt_q != 2'd3)
		else $error("padding count overran");

	// a pull taken with a full row produces a byte result
	a_pull_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == pru_pkg::FUNC_PULL && row_full_q |=> valid_s1 && ctl_s1.out_valid)
		else $error("pull on full row lost its byte");

endmodule

// File: tb/pru_tb_pkg.sv
// ----------------------------------------------------------------------------
// pru_tb_pkg
// Scoreboard for the pixel replicating upscaler testbench. It keeps its own
// copy of the line store, the counters and the registers. It works out the
// result of every accepted request and checks the results the block returns.
// ----------------------------------------------------------------------------
package pru_tb_pkg;

	localparam int LINE_DEPTH = 4096;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);

	// one result beat as it leaves the block
	typedef struct packed {
		logic [7:0] data;
		logic       line_end;
		logic       group_end;
		logic       taken;
		logic       valid;
	} upscale_beat_t;

	class upscale_scoreboard;
		logic [23:0]      line_mem [LINE_DEPTH];
		int unsigned      written_hw;
		int unsigned      fill_cnt;
		bit               row_full;
		int unsigned      copy_cnt;
		int unsigned      src_idx;
		int unsigned      rep_cnt;
		pru_pkg::phase_t  phase;
		int unsigned      pad_cnt;
		logic [4:0]       scale_reg;
		logic [12:0]      width_reg;
		upscale_beat_t    expected_beats [$];
		int               errors;

		function new();
			written_hw = 0;
			fill_cnt   = 0;
			row_full   = 1'b0;
			copy_cnt   = 0;
			src_idx    = 0;
			rep_cnt    = 0;
			phase      = pru_pkg::PH_BLUE;
			pad_cnt    = 0;
			scale_reg  = 5'd1;
			width_reg  = 13'd1;
			errors     = 0;
		endfunction

		function void set_reg(logic [2:0] addr, logic [31:0] val);
			if (addr == pru_pkg::REG_SCALE)
				scale_reg = val[4:0];
			else if (addr == pru_pkg::REG_IN_WIDTH)
				width_reg = val[12:0];
		endfunction

		function int unsigned eff_scale();
			if (scale_reg == 0)
				return 1;
			if (scale_reg > 16)
				return 16;
			return 32'(scale_reg);
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_DEPTH)
				return LINE_DEPTH;
			return 32'(width_reg);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// close one output line; returns 1 when the last copy is done
		function bit end_line(int unsigned s);
			src_idx = 0;
			rep_cnt = 0;
			phase   = pru_pkg::PH_BLUE;
			pad_cnt = 0;
			if (copy_cnt + 1 >= s) begin
				copy_cnt = 0;
				row_full = 1'b0;
				fill_cnt = 0;
				return 1'b1;
			end
			copy_cnt = copy_cnt + 1;
			return 1'b0;
		endfunction

		// advance the copy of the block state by one accepted request
		function void note_request(logic func, logic [23:0] pix);
			upscale_beat_t b;
			int unsigned   s;
			int unsigned   w;
			int unsigned   pad;
			b   = '0;
			s   = eff_scale();
			w   = eff_width();
			pad = (4 - ((w * s * 3) & 3)) & 3;
			if (func == pru_pkg::FUNC_PUSH) begin
				if (!row_full && fill_cnt < LINE_DEPTH) begin
					line_mem[LINE_AW'(fill_cnt)] = pix;
					fill_cnt = fill_cnt + 1;
					if (fill_cnt > written_hw)
						written_hw = fill_cnt;
					if (fill_cnt >= w)
						row_full = 1'b1;
					b.taken = 1'b1;
				end
			end else if (row_full) begin
				b.valid = 1'b1;
				if (phase == pru_pkg::PH_PAD) begin
					b.data  = 8'h00;
					pad_cnt = pad_cnt + 1;
					if (pad_cnt >= pad) begin
						b.line_end  = 1'b1;
						b.group_end = end_line(s);
					end
				end else begin
					case (phase)
						pru_pkg::PH_BLUE:  b.data = line_mem[LINE_AW'(src_idx)][7:0];
						pru_pkg::PH_GREEN: b.data = line_mem[LINE_AW'(src_idx)][15:8];
						default:           b.data = line_mem[LINE_AW'(src_idx)][23:16];
					endcase
					if (phase == pru_pkg::PH_RED) begin
						phase   = pru_pkg::PH_BLUE;
						rep_cnt = rep_cnt + 1;
						if (rep_cnt >= s) begin
							rep_cnt = 0;
							if (src_idx + 1 >= w) begin
								if (pad > 0) begin
									phase   = pru_pkg::PH_PAD;
									pad_cnt = 0;
								end else begin
									b.line_end  = 1'b1;
									b.group_end = end_line(s);
								end
							end else begin
								src_idx = src_idx + 1;
							end
						end
					end else begin
						phase = (phase == pru_pkg::PH_BLUE) ? pru_pkg::PH_GREEN
							: pru_pkg::PH_RED;
					end
				end
			end
			expected_beats.push_back(b);
		endfunction

		// compare one returned beat with the oldest expected one
		function void check_beat(upscale_beat_t got);
			upscale_beat_t exp_beat;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: byte %h last %b group %b taken %b valid %b",
						got.data, got.line_end, got.group_end, got.taken, got.valid);
				return;
			end
			exp_beat = expected_beats.pop_front();
			if (got !== exp_beat) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected byte %h last %b group %b taken %b valid %b,",
						" got byte %h last %b group %b taken %b valid %b"},
						exp_beat.data, exp_beat.line_end, exp_beat.group_end, exp_beat.taken,
						exp_beat.valid, got.data, got.line_end, got.group_end, got.taken,
						got.valid);
			end
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel replicating upscaler. Push and pull
// requests go in on the s stream, every result beat is checked against the
// scoreboard, registers are rewritten between phases and in the middle of
// held rows, and both stream sides idle and stall in several patterns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int HOLD_LEN       = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 1000;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	pru_tb_pkg::upscale_scoreboard sb;
	int src_idle     = 0;
	int snk_stall    = 0;
	int hold_reqs    = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int sent_items   = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	pixel_replicate_upscaler #(
		.MAX_WIDTH(pru_tb_pkg::LINE_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// result check and receiver ready, with long hold-offs on demand
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_beat({m_tdata, m_tlast, m_tuser[1], m_tuser[2], m_tuser[0]});
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_served != hold_reqs) begin
			hold_served++;
			hold_left = HOLD_LEN - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall);
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one request, with random gaps before it, and note it once taken
	task automatic send_request(input logic func, input logic [23:0] pix);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(func, pix);
		sent_items++;
	endtask

	// wait for every outstanding result, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one apb write, setup then access; psel stays up for a following write
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(addr, val);
	endtask

	// write both registers, junk in the unused upper bits
	task automatic set_config(input logic [4:0] sc, input logic [12:0] wd);
		logic [31:0] junk;
		junk = $urandom();
		apb_write(pru_pkg::REG_SCALE, {junk[31:5], sc});
		junk = $urandom();
		apb_write(pru_pkg::REG_IN_WIDTH, {junk[31:13], wd});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// empty a held row, go idle and load new settings
	task automatic reconfigure(input logic [4:0] sc, input logic [12:0] wd);
		while (sb.row_full)
			send_request(pru_pkg::FUNC_PULL, 24'($urandom()));
		drain();
		set_config(sc, wd);
	endtask

	// new settings while a row is held; width never reaches unwritten entries
	task automatic change_mid_row();
		int unsigned top;
		drain();
		top = (sb.written_hw < 4) ? sb.written_hw : 4;
		set_config(5'($urandom_range(0, 6)), 13'($urandom_range(0, top)));
	endtask

	// fill a row and read it all back, with stray requests mixed in
	task automatic send_row(input bit allow_mid);
		bit mid_done;
		mid_done = !allow_mid;
		while (!sb.row_full) begin
			if ($urandom_range(15) == 0)
				send_request(pru_pkg::FUNC_PULL, 24'($urandom()));
			else
				send_request(pru_pkg::FUNC_PUSH, 24'($urandom()));
		end
		while (sb.row_full) begin
			if ($urandom_range(15) == 0) begin
				send_request(pru_pkg::FUNC_PUSH, 24'($urandom()));
			end else if (!mid_done && $urandom_range(79) == 0) begin
				change_mid_row();
				mid_done = 1'b1;
			end else begin
				send_request(pru_pkg::FUNC_PULL, 24'($urandom()));
			end
		end
	endtask

	// scale value, code zero now and then, larger repeats kept moderate
	function automatic logic [4:0] pick_scale();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return 5'd0;
		if (r < 20)
			return 5'($urandom_range(5, 6));
		return 5'($urandom_range(1, 4));
	endfunction

	// width value, kept tiny when the scale is large, wide only at scale one
	function automatic logic [12:0] pick_width(input logic [4:0] sc);
		int unsigned r;
		if (sc >= 5)
			return 13'($urandom_range(0, 2));
		r = $urandom_range(99);
		if (r < 8)
			return 13'd0;
		if (r < 12 && sc <= 1)
			return 13'($urandom_range(9, 40));
		return 13'($urandom_range(1, 8));
	endfunction

	initial begin
		int          job;
		int          base;
		logic [4:0]  sc;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pull on an empty row, extreme pixels, drop while full, padded line
		send_request(pru_pkg::FUNC_PULL, 24'hFFFFFF);
		send_request(pru_pkg::FUNC_PUSH, 24'h000000);
		send_request(pru_pkg::FUNC_PUSH, 24'hFFFFFF);
		repeat (4) send_request(pru_pkg::FUNC_PULL, 24'h000000);
		drain();

		// scale code zero, two pixels, pull before the row is full
		set_config(5'd0, 13'd2);
		send_request(pru_pkg::FUNC_PUSH, 24'hFFFFFF);
		send_request(pru_pkg::FUNC_PULL, 24'h000000);
		send_request(pru_pkg::FUNC_PUSH, 24'h3CA55A);
		repeat (8) send_request(pru_pkg::FUNC_PULL, 24'h000000);

		// width at the store depth and a code above it on a partly filled row,
		// then a narrow width closes the row
		reconfigure(5'd1, 13'd4096);
		repeat (3) send_request(pru_pkg::FUNC_PUSH, 24'($urandom()));
		reconfigure(5'd0, 13'd8191);
		send_request(pru_pkg::FUNC_PUSH, 24'($urandom()));
		reconfigure(5'd1, 13'd2);
		send_row(1'b0);

		// largest scale and a code above it: one full line of repeats,
		// then scale one ends the held row
		reconfigure(5'd16, 13'd1);
		send_request(pru_pkg::FUNC_PUSH, 24'h123456);
		repeat (48) send_request(pru_pkg::FUNC_PULL, 24'h000000);
		drain();
		set_config(5'd1, 13'd1);
		send_row(1'b0);
		reconfigure(5'd31, 13'd1);
		send_request(pru_pkg::FUNC_PUSH, 24'hA5C3E7);
		repeat (48) send_request(pru_pkg::FUNC_PULL, 24'h000000);
		drain();
		set_config(5'd1, 13'd1);
		send_row(1'b0);

		// random rows under changing settings and idle patterns
		base = sent_items;
		job  = 0;
		while (sent_items - base < RANDOM_ITEMS) begin
			case (job % 4)
				0: begin
					src_idle = 0;
					snk_stall <= 0;
				end
				1: begin
					src_idle = 66;
					snk_stall <= 0;
				end
				2: begin
					src_idle = 0;
					snk_stall <= 66;
				end
				default: begin
					src_idle = 11;
					snk_stall <= 11;
				end
			endcase
			if (job % 4 == 0 && (job == 0 || $urandom_range(3) == 0)) begin
				// receiver holds off while pulls keep coming
				reconfigure(5'd4, 13'd6);
				hold_reqs <= hold_reqs + 1;
			end else if ($urandom_range(1) == 0) begin
				sc = pick_scale();
				reconfigure(sc, pick_width(sc));
			end
			send_row(1'b1);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 6))
					send_request(logic'($urandom_range(1)), 24'($urandom()));
			job++;
		end

		// let the last results out
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: pixel_replicate_upscaler.f
rtl/core/pru_pkg.sv
rtl/core/pixel_replicate_upscaler.sv
tb/pru_tb_pkg.sv
tb/tb_top.sv
